// ===== design/ckad_pkg.sv =====
// Shared types and constants for the chroma key with despill block.
// No dependencies; used by every module of the block.
package ckad_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

    typedef struct packed {
        logic zero;
        logic one;
    } ramp_t;

    localparam int SUM_WIDTH = 18;
    localparam logic [SUM_WIDTH-1:0] NORM_DIVISOR = 18'd195075;
    localparam logic [15:0] SOFT_MIN = 16'd33;
    localparam logic [16:0] FACTOR_ONE = 17'd65536;
    localparam logic [16:0] EDGE_LIMIT = 17'd64881;
    localparam int QUOT_BITS = 16;

    localparam logic [2:0] REG_KEY_ENABLE = 3'd0;
    localparam logic [2:0] REG_KEY_RED = 3'd1;
    localparam logic [2:0] REG_KEY_GREEN = 3'd2;
    localparam logic [2:0] REG_KEY_BLUE = 3'd3;
    localparam logic [2:0] REG_TOLERANCE = 3'd4;
    localparam logic [2:0] REG_SOFTNESS = 3'd5;

endpackage

// ===== design/ckad_sqrt_cell.sv =====
// One bit of the normalized distance square root: trial subtract of the scaled square.
// Depends on ckad_pkg.
module ckad_sqrt_cell #(
    parameter int FRAC_BITS = 15,
    parameter int BIT_POS = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [ckad_pkg::SUM_WIDTH+2*FRAC_BITS-1:0] rem_in,
    input  logic [ckad_pkg::SUM_WIDTH+FRAC_BITS:0] dd_in,
    input  logic [FRAC_BITS:0] root_in,
    input  ckad_pkg::pix_t pix_in,
    output logic out_valid,
    input  logic out_ready,
    output logic [ckad_pkg::SUM_WIDTH+2*FRAC_BITS-1:0] rem_out,
    output logic [ckad_pkg::SUM_WIDTH+FRAC_BITS:0] dd_out,
    output logic [FRAC_BITS:0] root_out,
    output ckad_pkg::pix_t pix_out
);
    localparam int RW = ckad_pkg::SUM_WIDTH + 2*FRAC_BITS;
    localparam int DW = ckad_pkg::SUM_WIDTH + FRAC_BITS + 1;
    localparam int TW = RW + 3;
    localparam int QW = FRAC_BITS + 1;

    logic valid_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dd_reg, dd_next;
    logic [QW-1:0] root_reg, root_next;
    ckad_pkg::pix_t pix_reg;
    logic [TW-1:0] delta;
    logic take;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        delta = (TW'(dd_in) << (BIT_POS + 1))
              + (TW'(ckad_pkg::NORM_DIVISOR) << (2*BIT_POS));
        take = delta <= TW'(rem_in);
        rem_next = take ? RW'(TW'(rem_in) - delta) : rem_in;
        dd_next = take ? dd_in + (DW'(ckad_pkg::NORM_DIVISOR) << BIT_POS) : dd_in;
        root_next = take ? (root_in | (QW'(1) << BIT_POS)) : root_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg <= rem_next;
            dd_reg <= dd_next;
            root_reg <= root_next;
            pix_reg <= pix_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out = rem_reg;
    assign dd_out = dd_reg;
    assign root_out = root_reg;
    assign pix_out = pix_reg;
endmodule

// ===== design/ckad_div_cell.sv =====
// One quotient bit of the alpha ramp division: restoring shift-subtract by the softness.
// Depends on ckad_pkg.
module ckad_div_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic [15:0] divisor,
    input  logic in_valid,
    output logic in_ready,
    input  logic [15:0] rem_in,
    input  logic [15:0] quot_in,
    input  ckad_pkg::ramp_t ramp_in,
    input  ckad_pkg::pix_t pix_in,
    output logic out_valid,
    input  logic out_ready,
    output logic [15:0] rem_out,
    output logic [15:0] quot_out,
    output ckad_pkg::ramp_t ramp_out,
    output ckad_pkg::pix_t pix_out
);
    logic valid_reg;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quot_reg, quot_next;
    ckad_pkg::ramp_t ramp_reg;
    ckad_pkg::pix_t pix_reg;
    logic [16:0] trial;
    logic take;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        trial = {rem_in, 1'b0};
        take = trial >= {1'b0, divisor};
        rem_next = take ? 16'(trial - {1'b0, divisor}) : trial[15:0];
        quot_next = {quot_in[14:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg <= rem_next;
            quot_reg <= quot_next;
            ramp_reg <= ramp_in;
            pix_reg <= pix_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out = rem_reg;
    assign quot_out = quot_reg;
    assign ramp_out = ramp_reg;
    assign pix_out = pix_reg;
endmodule

// ===== design/chroma_key_alpha_despill.sv =====
// Top level of the chroma key with despill block: registers, front and back stages, cell chains.
// Depends on ckad_pkg, ckad_sqrt_cell and ckad_div_cell.
//
// One pixel per clock is accepted and one keyed pixel per clock is delivered while out_ready
// holds. Each pixel passes through a register for the squared distance, one cell per
// distance bit for the square root, a register for the tolerance compare, sixteen cells
// for the alpha ramp division, and an output register. Every stage holds its own
// transaction, so a stalled output only backs up until the bubbles close.
// Write configuration only while no pixel is in flight.
module chroma_key_alpha_despill #(
    parameter int DIST_FRACTION_BITS = 15
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic [7:0] alpha_in,
    output logic out_valid,
    input  logic out_ready,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [7:0] alpha_out
);
    localparam int F = DIST_FRACTION_BITS;
    localparam int SW = ckad_pkg::SUM_WIDTH;
    localparam int RW = SW + 2*F;
    localparam int DW = SW + F + 1;
    localparam int QW = F + 1;
    localparam int NS = F + 1;
    localparam int ND = ckad_pkg::QUOT_BITS;
    localparam int CW = (F + 1 > 17) ? F + 2 : 18;

    logic key_enable_reg;
    logic [7:0] key_red_reg, key_green_reg, key_blue_reg;
    logic [15:0] tol_reg, soft_cfg_reg;
    logic [15:0] softness;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_enable_reg <= 1'b0;
            key_red_reg <= 8'd0;
            key_green_reg <= 8'd255;
            key_blue_reg <= 8'd0;
            tol_reg <= 16'd3277;
            soft_cfg_reg <= 16'd3277;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ckad_pkg::REG_KEY_ENABLE: key_enable_reg <= cfg_data[0];
                ckad_pkg::REG_KEY_RED: key_red_reg <= cfg_data[7:0];
                ckad_pkg::REG_KEY_GREEN: key_green_reg <= cfg_data[7:0];
                ckad_pkg::REG_KEY_BLUE: key_blue_reg <= cfg_data[7:0];
                ckad_pkg::REG_TOLERANCE: tol_reg <= cfg_data;
                ckad_pkg::REG_SOFTNESS: soft_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign softness = (soft_cfg_reg < ckad_pkg::SOFT_MIN) ? ckad_pkg::SOFT_MIN : soft_cfg_reg;

    // front stage: squared distance
    logic v0_reg, rdy0;
    logic [SW-1:0] sum_reg, sum_next;
    ckad_pkg::pix_t pix0_reg, pix_in;
    logic [7:0] dr, dg, db;
    logic sq_ready [0:NS];
    logic sq_valid [0:NS];
    logic [RW-1:0] sq_rem [0:NS];
    logic [DW-1:0] sq_dd [0:NS];
    logic [QW-1:0] sq_root [0:NS];
    ckad_pkg::pix_t sq_pix [0:NS];

    assign pix_in = '{red: red_in, green: green_in, blue: blue_in, alpha: alpha_in};
    assign rdy0 = !v0_reg || sq_ready[0];
    assign in_ready = rdy0;

    always_comb
    begin
        dr = (red_in > key_red_reg) ? red_in - key_red_reg : key_red_reg - red_in;
        dg = (green_in > key_green_reg) ? green_in - key_green_reg : key_green_reg - green_in;
        db = (blue_in > key_blue_reg) ? blue_in - key_blue_reg : key_blue_reg - blue_in;
        sum_next = SW'(16'(dr) * 16'(dr)) + SW'(16'(dg) * 16'(dg)) + SW'(16'(db) * 16'(db));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (rdy0)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy0)
        begin
            sum_reg <= sum_next;
            pix0_reg <= pix_in;
        end
    end

    assign sq_valid[0] = v0_reg;
    assign sq_rem[0] = RW'(sum_reg) << (2*F);
    assign sq_dd[0] = '0;
    assign sq_root[0] = '0;
    assign sq_pix[0] = pix0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        ckad_sqrt_cell #(
            .FRAC_BITS(F),
            .BIT_POS(F - i)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .in_valid(sq_valid[i]),
            .in_ready(sq_ready[i]),
            .rem_in(sq_rem[i]),
            .dd_in(sq_dd[i]),
            .root_in(sq_root[i]),
            .pix_in(sq_pix[i]),
            .out_valid(sq_valid[i+1]),
            .out_ready(sq_ready[i+1]),
            .rem_out(sq_rem[i+1]),
            .dd_out(sq_dd[i+1]),
            .root_out(sq_root[i+1]),
            .pix_out(sq_pix[i+1])
        );
    end

    // middle stage: tolerance compare
    logic vm_reg, rdym;
    logic [15:0] num_reg;
    ckad_pkg::ramp_t ramp_reg, ramp_next;
    ckad_pkg::pix_t pixm_reg;
    logic [CW-1:0] dist_ext, diff;
    logic dv_ready [0:ND];
    logic dv_valid [0:ND];
    logic [15:0] dv_rem [0:ND];
    logic [15:0] dv_quot [0:ND];
    ckad_pkg::ramp_t dv_ramp [0:ND];
    ckad_pkg::pix_t dv_pix [0:ND];

    assign rdym = !vm_reg || dv_ready[0];
    assign sq_ready[NS] = rdym;

    always_comb
    begin
        dist_ext = CW'(sq_root[NS]);
        diff = dist_ext - CW'(tol_reg);
        ramp_next.zero = dist_ext < CW'(tol_reg);
        ramp_next.one = dist_ext >= CW'(17'(tol_reg) + 17'(softness));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (rdym)
        begin
            vm_reg <= sq_valid[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_valid[NS] && rdym)
        begin
            num_reg <= diff[15:0];
            ramp_reg <= ramp_next;
            pixm_reg <= sq_pix[NS];
        end
    end

    assign dv_valid[0] = vm_reg;
    assign dv_rem[0] = num_reg;
    assign dv_quot[0] = '0;
    assign dv_ramp[0] = ramp_reg;
    assign dv_pix[0] = pixm_reg;

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        ckad_div_cell u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .divisor(softness),
            .in_valid(dv_valid[j]),
            .in_ready(dv_ready[j]),
            .rem_in(dv_rem[j]),
            .quot_in(dv_quot[j]),
            .ramp_in(dv_ramp[j]),
            .pix_in(dv_pix[j]),
            .out_valid(dv_valid[j+1]),
            .out_ready(dv_ready[j+1]),
            .rem_out(dv_rem[j+1]),
            .quot_out(dv_quot[j+1]),
            .ramp_out(dv_ramp[j+1]),
            .pix_out(dv_pix[j+1])
        );
    end

    // output stage: alpha scale and despill
    logic vo_reg, rdyo;
    ckad_pkg::pix_t pixo_reg, pixo_next, pf;
    logic [16:0] factor;
    logic [24:0] prod;
    logic [8:0] pair;
    logic is_edge, green_key, blue_key;

    assign rdyo = !vo_reg || out_ready;
    assign dv_ready[ND] = rdyo;

    always_comb
    begin
        pf = dv_pix[ND];
        if (dv_ramp[ND].one)
            factor = ckad_pkg::FACTOR_ONE;
        else if (dv_ramp[ND].zero)
            factor = '0;
        else
            factor = {1'b0, dv_quot[ND]};
        is_edge = (factor != '0) && (factor < ckad_pkg::EDGE_LIMIT);
        green_key = (key_green_reg > key_red_reg) && (key_green_reg > key_blue_reg);
        blue_key = (key_blue_reg > key_red_reg) && (key_blue_reg > key_green_reg);
        prod = 25'(pf.alpha) * 25'(factor);
        pixo_next = pf;
        pair = '0;
        if (key_enable_reg)
        begin
            pixo_next.alpha = prod[23:16];
            if (is_edge && green_key)
            begin
                pair = 9'(pf.red) + 9'(pf.blue);
                if (pf.green > pair[8:1])
                    pixo_next.green = pair[8:1];
            end
            else if (is_edge && blue_key)
            begin
                pair = 9'(pf.red) + 9'(pf.green);
                if (pf.blue > pair[8:1])
                    pixo_next.blue = pair[8:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (rdyo)
        begin
            vo_reg <= dv_valid[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_valid[ND] && rdyo)
        begin
            pixo_reg <= pixo_next;
        end
    end

    assign out_valid = vo_reg;
    assign red_out = pixo_reg.red;
    assign green_out = pixo_reg.green;
    assign blue_out = pixo_reg.blue;
    assign alpha_out = pixo_reg.alpha;
endmodule

// ===== verif/tb.sv =====
// Testbench for chroma_key_alpha_despill: directed and random pixels through valid/ready.
// Depends on ckad_pkg and the block; a local keying predictor checks every output pixel.
`timescale 1ns / 100ps

module tb;
    localparam int FRAC = 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [7:0] red_in, green_in, blue_in, alpha_in;
    logic out_valid;
    logic out_ready;
    logic [7:0] red_out, green_out, blue_out, alpha_out;

    chroma_key_alpha_despill #(.DIST_FRACTION_BITS(FRAC)) uut (.*);

    logic kc_enable;
    logic [7:0] kc_red, kc_green, kc_blue;
    logic [15:0] kc_tol, kc_soft;

    ckad_pkg::pix_t pending_pixels[$];
    ckad_pkg::pix_t keyed_expected[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    int in_gap = 0;
    int out_gap = 0;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned step;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            step = root | (64'd1 << i);
            if (step * step <= v)
                root = step;
        end
        return root;
    endfunction

    function automatic ckad_pkg::pix_t key_pixel(ckad_pkg::pix_t p);
        ckad_pkg::pix_t q;
        longint unsigned sum, scaled, distance, soft_eff, factor, lim;
        int dr, dg, db;
        q = p;
        if (!kc_enable)
            return q;
        dr = int'(p.red) - int'(kc_red);
        dg = int'(p.green) - int'(kc_green);
        db = int'(p.blue) - int'(kc_blue);
        sum = dr * dr + dg * dg + db * db;
        scaled = (sum << (2 * FRAC)) / 195075;
        distance = int_sqrt(scaled);
        soft_eff = (kc_soft < ckad_pkg::SOFT_MIN) ? ckad_pkg::SOFT_MIN : kc_soft;
        if (distance < kc_tol)
            factor = 0;
        else if (distance < kc_tol + soft_eff)
            factor = ((distance - kc_tol) * 65536) / soft_eff;
        else
            factor = 65536;
        if (factor > 0 && factor < ckad_pkg::EDGE_LIMIT)
        begin
            if (kc_green > kc_red && kc_green > kc_blue)
            begin
                lim = (p.red + p.blue) >> 1;
                if (p.green > lim)
                    q.green = lim[7:0];
            end
            else if (kc_blue > kc_red && kc_blue > kc_green)
            begin
                lim = (p.red + p.green) >> 1;
                if (p.blue > lim)
                    q.blue = lim[7:0];
            end
        end
        lim = (p.alpha * factor) >> 16;
        q.alpha = lim[7:0];
        return q;
    endfunction

    function automatic ckad_pkg::pix_t rand_pixel();
        ckad_pkg::pix_t p;
        p = $urandom;
        if ($urandom_range(0, 2) == 0)
        begin
            p.red = kc_red + 8'($urandom_range(0, 40)) - 8'd20;
            p.green = kc_green + 8'($urandom_range(0, 40)) - 8'd20;
            p.blue = kc_blue + 8'($urandom_range(0, 40)) - 8'd20;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            red_in <= 8'd0;
            green_in <= 8'd0;
            blue_in <= 8'd0;
            alpha_in <= 8'd0;
            in_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready)
                keyed_expected.push_back(key_pixel({red_in, green_in, blue_in, alpha_in}));
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                {red_in, green_in, blue_in, alpha_in} <= pending_pixels.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    in_gap <= $urandom_range(1, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
                out_gap <= $urandom_range(1, 17);
        end
    end

    always @(posedge clk)
    begin
        ckad_pkg::pix_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (keyed_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel %h %h %h %h",
                                 red_out, green_out, blue_out, alpha_out);
                end
                else
                begin
                    want = keyed_expected.pop_front();
                    if (want != {red_out, green_out, blue_out, alpha_out})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: expected %h %h %h %h got %h %h %h %h",
                                     want.red, want.green, want.blue, want.alpha,
                                     red_out, green_out, blue_out, alpha_out);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ckad_pkg::REG_KEY_ENABLE: kc_enable = val[0];
            ckad_pkg::REG_KEY_RED: kc_red = val[7:0];
            ckad_pkg::REG_KEY_GREEN: kc_green = val[7:0];
            ckad_pkg::REG_KEY_BLUE: kc_blue = val[7:0];
            ckad_pkg::REG_TOLERANCE: kc_tol = val;
            ckad_pkg::REG_SOFTNESS: kc_soft = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || in_valid || keyed_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_key(logic en, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [15:0] tol, logic [15:0] softness);
        write_reg(ckad_pkg::REG_KEY_ENABLE, {15'($urandom_range(0, 32767)), en});
        write_reg(ckad_pkg::REG_KEY_RED, {8'($urandom), r});
        write_reg(ckad_pkg::REG_KEY_GREEN, {8'($urandom), g});
        write_reg(ckad_pkg::REG_KEY_BLUE, {8'($urandom), b});
        write_reg(ckad_pkg::REG_TOLERANCE, tol);
        write_reg(ckad_pkg::REG_SOFTNESS, softness);
        write_reg(3'd6, 16'hffff);
        write_reg(3'd7, 16'h0000);
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = 3'd0;
        cfg_data = 16'd0;
        kc_enable = 1'b0;
        kc_red = 8'd0;
        kc_green = 8'd255;
        kc_blue = 8'd0;
        kc_tol = 16'd3277;
        kc_soft = 16'd3277;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        pending_pixels.push_back('0);
        pending_pixels.push_back('1);
        pending_pixels.push_back(32'h12345678);
        wait_drained();

        set_key(1'b1, 8'd0, 8'd255, 8'd0, 16'd3277, 16'd3277);
        pending_pixels.push_back({8'd0, 8'd255, 8'd0, 8'd255});
        pending_pixels.push_back({8'd255, 8'd0, 8'd255, 8'd255});
        pending_pixels.push_back({8'd30, 8'd240, 8'd20, 8'd255});
        pending_pixels.push_back({8'd60, 8'd220, 8'd40, 8'd200});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 8'd0});
        wait_drained();

        set_key(1'b1, 8'd10, 8'd20, 8'd250, 16'd0, 16'd0);
        pending_pixels.push_back({8'd10, 8'd20, 8'd250, 8'd255});
        pending_pixels.push_back({8'd10, 8'd20, 8'd249, 8'd255});
        pending_pixels.push_back({8'd40, 8'd30, 8'd200, 8'd128});
        wait_drained();

        set_key(1'b1, 8'd100, 8'd100, 8'd100, 16'hffff, 16'hffff);
        pending_pixels.push_back({8'd0, 8'd0, 8'd0, 8'd255});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 8'd255});
        wait_drained();

        set_key(1'b1, 8'd255, 8'd0, 8'd0, 16'd1000, 16'd32768);
        pending_pixels.push_back({8'd200, 8'd50, 8'd50, 8'd255});
        pending_pixels.push_back({8'd0, 8'd255, 8'd255, 8'd255});
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            set_key(phase != 7, 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom_range(0, 12000)),
                    (phase == 3) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(0, 20000)));
            if (phase == 0)
                write_reg(ckad_pkg::REG_KEY_GREEN, 16'd255);
            if (phase == 7)
                quiet = 1;
            for (int i = 0; i < 105; i++)
                pending_pixels.push_back(rand_pixel());
            wait_drained();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
